### rtl/core/kwm_pkg.sv
package kwm_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CNT_W     = 31;
    localparam int HASH_W    = 64;
    localparam int BID_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SELECTED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT    = 8'd1;

    localparam logic OP_ENTRY = 1'b0;
    localparam logic OP_EMPTY = 1'b1;

    localparam logic KIND_SELECT = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic              op;
        logic [BID_W-1:0]  bucket_id;
        logic [HASH_W-1:0] entry_hash;
        logic [CNT_W-1:0]  entry_count;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [HASH_W-1:0] selected_hash;
        logic [CNT_W-1:0]  selected_freq;
        logic [BID_W-1:0]  refill_bucket;
        logic [CNT_W-1:0]  total_selected;
    } t_out;

    // one bucket head as stored in the head memory
    typedef struct packed {
        logic              vld;
        logic [CNT_W-1:0]  count;
        logic [HASH_W-1:0] hash;
    } t_head;

endpackage

### rtl/core/top_count_kway_merge.sv
// K-way merge by count. The first BUCKET_COUNT input beats load the bucket
// heads in bucket order (bucket_id is not looked at); each later beat is the
// refill of the bucket named in the previous result. Loading beats do not stall
// the input. After the last load and after each refill, the block reads all
// BUCKET_COUNT heads from its head memory, one per cycle through a single
// compare unit, and the result then waits while an earlier result is still
// held at the output; input stall is high from the accepted beat until the
// result is registered, and during reset. A
// finished result is followed by no more results until reset; later beats
// are taken and dropped.
module top_count_kway_merge #(
    parameter int BUCKET_COUNT = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  kwm_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output kwm_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kwm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kwm_pkg::CNT_W-1:0]     i_cfg_data
);
    import kwm_pkg::*;

    localparam int AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(BUCKET_COUNT - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_loading;
    logic [AW-1:0]    r_load_idx;
    logic [AW-1:0]    r_pending;
    logic [AW-1:0]    r_addr;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;
    logic [CNT_W-1:0] r_emitted;
    logic             r_finished;
    logic [CNT_W-1:0] r_max_sel;
    logic [CNT_W-1:0] r_min_cnt;
    logic             r_out_vld;
    t_out             r_out;

    logic              w_in_acc;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    t_head             w_wr_data;
    t_head             w_rd_data;
    logic              w_found;
    logic [CNT_W-1:0]  w_best_cnt;
    logic [HASH_W-1:0] w_best_hash;
    logic [AW-1:0]     w_best_idx;
    logic              w_stop;
    logic              w_out_free;
    logic              w_emit;
    logic              w_start;
    logic [CNT_W-1:0]  w_emitted_inc;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = !i_rst_n || (r_state != ST_IDLE);
    assign o_cfg_ready = i_rst_n;

    assign w_wr_en   = w_in_acc && !r_finished;
    assign w_wr_addr = r_loading ? r_load_idx : r_pending;
    assign w_wr_data.vld   = (i_in_data.op == OP_ENTRY);
    assign w_wr_data.count = i_in_data.entry_count;
    assign w_wr_data.hash  = i_in_data.entry_hash;

    // a scan follows every refill and the final load beat
    assign w_start = w_wr_en && (!r_loading || (r_load_idx == LAST_IDX));

    kwm_head_mem #(
        .DEPTH (BUCKET_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    kwm_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_start),
        .i_vld   (r_rd_vld),
        .i_idx   (r_rd_idx),
        .i_entry (w_rd_data),
        .o_found (w_found),
        .o_count (w_best_cnt),
        .o_hash  (w_best_hash),
        .o_idx   (w_best_idx)
    );

    assign w_out_free    = !r_out_vld || !i_out_stall;
    assign w_emit        = (r_state == ST_EMIT) && w_out_free;
    assign w_stop        = ((r_max_sel != '0) && (r_emitted >= r_max_sel)) ||
                           !w_found || (w_best_cnt < r_min_cnt);
    assign w_emitted_inc = (r_emitted == CNT_MAX) ? r_emitted : r_emitted + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_start) n_state = ST_SCAN;
            ST_SCAN:  if (r_addr == LAST_IDX) n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_EMIT;
            ST_EMIT:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_loading  <= 1'b1;
            r_load_idx <= '0;
            r_pending  <= '0;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_emitted  <= '0;
            r_finished <= 1'b0;
            r_max_sel  <= '0;
            r_min_cnt  <= CNT_W'(1);
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_SELECTED) begin
                    r_max_sel <= i_cfg_data;
                end else if (i_cfg_index == CFG_MIN_COUNT) begin
                    r_min_cnt <= i_cfg_data;
                end
            end

            if (w_wr_en && r_loading) begin
                r_load_idx <= r_load_idx + 1'b1;
                if (r_load_idx == LAST_IDX) begin
                    r_loading <= 1'b0;
                end
            end

            // address counter walks all heads; the read data and its index are registered
            r_rd_vld <= (r_state == ST_SCAN);
            r_rd_idx <= r_addr;
            if (r_state == ST_SCAN) begin
                r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
            end else begin
                r_addr <= '0;
            end

            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
                if (w_stop) begin
                    r_finished <= 1'b1;
                end else begin
                    r_emitted <= w_emitted_inc;
                    r_pending <= w_best_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (w_stop) begin
                r_out.kind           <= KIND_DONE;
                r_out.selected_hash  <= '0;
                r_out.selected_freq  <= '0;
                r_out.refill_bucket  <= '0;
                r_out.total_selected <= r_emitted;
            end else begin
                r_out.kind           <= KIND_SELECT;
                r_out.selected_hash  <= w_best_hash;
                r_out.selected_freq  <= w_best_cnt;
                r_out.refill_bucket  <= BID_W'({{BID_W{1'b0}}, w_best_idx});
                r_out.total_selected <= w_emitted_inc;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### rtl/core/kwm_head_mem.sv
module kwm_head_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  kwm_pkg::t_head    i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output kwm_pkg::t_head    o_rd_data
);
    import kwm_pkg::*;

    t_head r_mem [DEPTH];
    t_head r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/kwm_scan.sv
module kwm_scan #(
    parameter int AW = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_vld,
    input  logic [AW-1:0]             i_idx,
    input  kwm_pkg::t_head            i_entry,
    output logic                      o_found,
    output logic [kwm_pkg::CNT_W-1:0] o_count,
    output logic [kwm_pkg::HASH_W-1:0] o_hash,
    output logic [AW-1:0]             o_idx
);
    import kwm_pkg::*;

    logic              r_found;
    logic [CNT_W-1:0]  r_count;
    logic [HASH_W-1:0] r_hash;
    logic [AW-1:0]     r_idx;
    logic              w_take;

    // ascending scan with >= on the hash gives ties to the larger bucket
    assign w_take = i_vld && i_entry.vld &&
                    (!r_found || (i_entry.count > r_count) ||
                     ((i_entry.count == r_count) && (i_entry.hash >= r_hash)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_clear && w_take) begin
            r_count <= i_entry.count;
            r_hash  <= i_entry.hash;
            r_idx   <= i_idx;
        end
    end

    assign o_found = r_found;
    assign o_count = r_count;
    assign o_hash  = r_hash;
    assign o_idx   = r_idx;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

import kwm_pkg::*;

localparam int NUM_HEADS = 128;
localparam logic [HASH_W-1:0] HASH_ONES = '1;

// tracks bucket heads and the picks the merge must produce
class pick_scoreboard;
    bit               head_vld[NUM_HEADS];
    logic [CNT_W-1:0] head_cnt[NUM_HEADS];
    logic [HASH_W-1:0] head_hsh[NUM_HEADS];
    int unsigned      loaded;
    logic [CNT_W-1:0] emitted;
    bit               done;
    int unsigned      pending;
    logic [CNT_W-1:0] max_sel;
    logic [CNT_W-1:0] min_cnt;
    t_out             picks_due[$];
    int unsigned      errors;
    int unsigned      checked;

    function new();
        foreach (head_vld[b]) begin
            head_vld[b] = 1'b0;
            head_cnt[b] = '0;
            head_hsh[b] = '0;
        end
        loaded  = 0;
        emitted = '0;
        done    = 1'b0;
        pending = 0;
        max_sel = '0;
        min_cnt = 1;
        errors  = 0;
        checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        if (idx == CFG_MAX_SELECTED)
            max_sel = val;
        else if (idx == CFG_MIN_COUNT)
            min_cnt = val;
    endfunction

    function void store_head(int unsigned b, t_in it);
        if (it.op == OP_ENTRY) begin
            head_vld[b] = 1'b1;
            head_hsh[b] = it.entry_hash;
            head_cnt[b] = it.entry_count;
        end else begin
            head_vld[b] = 1'b0;
        end
    endfunction

    function void pick_next();
        t_out r;
        int   best;
        bit   found;
        bit   stop;
        r     = '0;
        best  = 0;
        found = 1'b0;
        stop  = (max_sel != 0) && (emitted >= max_sel);
        if (!stop) begin
            for (int b = 0; b < NUM_HEADS; b++) begin
                if (head_vld[b] && (!found || head_cnt[b] > head_cnt[best] ||
                    (head_cnt[b] == head_cnt[best] && head_hsh[b] >= head_hsh[best]))) begin
                    best  = b;
                    found = 1'b1;
                end
            end
            if (!found || head_cnt[best] < min_cnt)
                stop = 1'b1;
        end
        if (stop) begin
            done             = 1'b1;
            r.kind           = KIND_DONE;
            r.total_selected = emitted;
        end else begin
            if (emitted != CNT_MAX)
                emitted++;
            head_vld[best]   = 1'b0;
            pending          = best;
            r.kind           = KIND_SELECT;
            r.selected_hash  = head_hsh[best];
            r.selected_freq  = head_cnt[best];
            r.refill_bucket  = BID_W'(best);
            r.total_selected = emitted;
        end
        picks_due = {picks_due, r};
    endfunction

    // loading beats fill heads in order, later beats refill the pending bucket
    function void take_item(t_in it);
        if (done)
            return;
        if (loaded < NUM_HEADS) begin
            store_head(loaded, it);
            loaded++;
            if (loaded == NUM_HEADS)
                pick_next();
        end else begin
            store_head(pending, it);
            pick_next();
        end
    endfunction

    function void check_pick(t_out got);
        t_out want;
        bit   same;
        checked++;
        if (picks_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: kind %0d hash %h freq %0d bucket %0d total %0d",
                         got.kind, got.selected_hash, got.selected_freq,
                         got.refill_bucket, got.total_selected);
            return;
        end
        want = picks_due.pop_front();
        same = (got.kind === want.kind) && (got.selected_hash === want.selected_hash) &&
               (got.selected_freq === want.selected_freq) &&
               (got.refill_bucket === want.refill_bucket) &&
               (got.total_selected === want.total_selected);
        if (!same) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch on result %0d", checked);
                $display("  expected kind %0d hash %h freq %0d bucket %0d total %0d",
                         want.kind, want.selected_hash, want.selected_freq,
                         want.refill_bucket, want.total_selected);
                $display("  actual   kind %0d hash %h freq %0d bucket %0d total %0d",
                         got.kind, got.selected_hash, got.selected_freq,
                         got.refill_bucket, got.total_selected);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int          SETTLE      = NUM_HEADS + 16;
    localparam int unsigned CYCLE_LIMIT = 900_000;
    localparam int          LONG_HOLD   = 300;
    localparam int          HOLD_EVERY  = 500;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b1;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CNT_W-1:0]     i_cfg_data  = '0;

    pick_scoreboard sb;
    int unsigned    send_idle_pct = 19;
    int unsigned    recv_idle_pct = 74;
    int unsigned    cycle_cnt     = 0;
    int unsigned    beats_in      = 0;
    int unsigned    results_got   = 0;
    int unsigned    hold_left     = 0;
    int unsigned    next_hold_at  = 0;
    int unsigned    long_holds    = 0;

    top_count_kway_merge #(.BUCKET_COUNT(NUM_HEADS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stall plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (i_rst_n && o_out_valid && results_got == next_hold_at) begin
            i_out_stall  <= 1'b1;
            hold_left    <= LONG_HOLD;
            next_hold_at <= next_hold_at + HOLD_EVERY;
            long_holds   <= long_holds + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_pick(o_out_data);
            results_got <= results_got + 1;
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
                 sb.picks_due.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_in entry_beat(logic op, logic [HASH_W-1:0] h, logic [CNT_W-1:0] c);
        t_in it;
        it.op          = op;
        it.bucket_id   = BID_W'($urandom);
        it.entry_hash  = h;
        it.entry_count = c;
        return it;
    endfunction

    // next beat of the pending bucket's stream, mostly in falling order
    function automatic t_in make_refill(int unsigned dry_pct);
        t_in              it;
        logic [CNT_W-1:0] last;
        int unsigned      roll;
        int unsigned      twin;
        last = sb.head_cnt[sb.pending];
        roll = $urandom_range(99);
        twin = $urandom_range(NUM_HEADS - 1);
        it = entry_beat(roll < dry_pct ? OP_EMPTY : OP_ENTRY, {$urandom, $urandom},
                        last - CNT_W'($urandom_range(last >> 3)));
        if (roll >= 95) begin
            it.entry_count = CNT_W'($urandom);
        end else if (roll >= 92 && sb.head_vld[twin]) begin
            // same count and hash as another live head
            it.entry_count = sb.head_cnt[twin];
            it.entry_hash  = sb.head_hsh[twin];
        end else if (roll >= 89) begin
            it.entry_hash = roll[0] ? HASH_ONES : '0;
        end
        return it;
    endfunction

    task automatic push_item(input t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_item(it);
        beats_in++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.picks_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int unsigned      roll;
        int unsigned      end_mode;
        int unsigned      guard;
        int unsigned      fails;
        logic [CNT_W-1:0] ms;
        logic [CNT_W-1:0] mc;
        string            finish_cause[3];

        finish_cause = '{"the emit limit", "every bucket running dry", "the count floor"};
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_MAX_SELECTED, CNT_MAX);
        write_reg(CFG_MIN_COUNT, '0);
        write_reg(CFG_IDX_W'($urandom_range(255, 2)), CNT_W'($urandom));
        i_cfg_valid <= 1'b0;

        // directed loads: count and hash extremes, ties, an empty bucket
        push_item(entry_beat(OP_ENTRY, '0, CNT_MAX));
        push_item(entry_beat(OP_ENTRY, HASH_ONES, CNT_MAX));
        push_item(entry_beat(OP_ENTRY, HASH_ONES, CNT_MAX));
        push_item(entry_beat(OP_EMPTY, HASH_ONES, CNT_MAX));
        push_item(entry_beat(OP_ENTRY, 64'h1, '0));
        push_item(entry_beat(OP_ENTRY, '0, '0));
        push_item(entry_beat(OP_ENTRY, 64'h1, CNT_MAX));
        push_item(entry_beat(OP_ENTRY, {$urandom, $urandom}, CNT_MAX - 1));
        while (sb.loaded < NUM_HEADS) begin
            roll = $urandom_range(99);
            push_item(entry_beat(roll < 3 ? OP_EMPTY : OP_ENTRY,
                                 roll > 94 ? (roll[0] ? HASH_ONES : '0) : {$urandom, $urandom},
                                 CNT_W'($urandom)));
        end

        // directed refills
        push_item(entry_beat(OP_EMPTY, '0, '0));
        push_item(entry_beat(OP_ENTRY, HASH_ONES, CNT_MAX));
        push_item(entry_beat(OP_ENTRY, '0, '0));

        // count floor at its top: a refill exactly at the floor still passes
        drain();
        write_reg(CFG_MIN_COUNT, CNT_MAX);
        i_cfg_valid <= 1'b0;
        push_item(entry_beat(OP_ENTRY, {$urandom, $urandom}, CNT_MAX));
        drain();
        write_reg(CFG_MIN_COUNT, 1);
        write_reg(CFG_MAX_SELECTED, '0);
        i_cfg_valid <= 1'b0;

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            if (ph < 3) begin
                send_idle_pct = 19;
                recv_idle_pct = 74;
            end else if (ph < 6) begin
                send_idle_pct = 74;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph % 3)
                0: ms = '0;
                1: ms = CNT_MAX;
                default: ms = sb.emitted + 2000;
            endcase
            case (ph % 4)
                1: mc = '0;
                2: mc = CNT_W'($urandom_range(5000, 1));
                default: mc = 1;
            endcase
            write_reg(CFG_MAX_SELECTED, ms);
            write_reg(CFG_MIN_COUNT, mc);
            i_cfg_valid <= 1'b0;
            repeat (145) begin
                if (!sb.done)
                    push_item(make_refill(3));
            end
        end

        // close the selection one of three ways
        drain();
        end_mode = $urandom_range(2);
        case (end_mode)
            0: write_reg(CFG_MAX_SELECTED, sb.emitted + CNT_W'($urandom_range(3)));
            1: begin
                write_reg(CFG_MAX_SELECTED, '0);
                write_reg(CFG_MIN_COUNT, '0);
            end
            default: write_reg(CFG_MIN_COUNT, CNT_MAX);
        endcase
        i_cfg_valid <= 1'b0;
        guard = 0;
        while (!sb.done && guard < 400) begin
            push_item(make_refill(end_mode == 1 ? 100 : 3));
            guard++;
        end

        // beats after the finish are taken and dropped
        repeat (6)
            push_item(entry_beat(1'($urandom_range(1)), {$urandom, $urandom}, CNT_W'($urandom)));
        drain();

        fails = sb.errors + sb.picks_due.size();
        $display("merge run: %0d beats in, %0d results checked, %0d long receiver holds",
                 beats_in, sb.checked, long_holds);
        $display("selection closed by %s after %0d picks, %0d cycles",
                 finish_cause[end_mode], sb.emitted, cycle_cnt);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
